[rtl/sale_pkg.sv]
package sale_pkg;

	localparam int DEPTH   = 32;
	localparam int KEY_W   = 32;
	localparam int PAY_W   = 32;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 6;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             ins;
		logic             del;
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
		logic [CNT_W-1:0] count;
	} cmd_t;

endpackage

[rtl/sorted_array_list_engine.sv]
// Channel  Dir  Signals                    Contents (lowest bit first)
// s_       in   tvalid tready tdata tuser  tdata: key[31:0] payload[63:32]; tuser: mode[1:0]
// m_       out  tvalid tready tdata tuser  tdata: found_payload[31:0] count[37:32] pad;
//                                          tuser: status[1:0]
//
// Insert and delete are done in the accepting edge: the row of cells compares every entry
// against the key at once and shifts in that same edge; clear only resets the entry count.
// Lookup is done by the binary search unit,
// which probes one entry per cycle through a read mux over the row.
// arst_n clears the entry count, the controller, the search flags and the output valid flag;
// entry storage is not reset. A stalled output holds the next transaction off.
module sorted_array_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key[31:0], payload[63:32]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // found_payload[31:0], count[37:32], zero[39:38]
	output logic [1:0]  m_tuser    // status[1:0]
);
	import sale_pkg::*;

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]  count_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [MODE_W-1:0] in_mode;
	logic [KEY_W-1:0]  in_key;
	logic [PAY_W-1:0]  in_payload;
	logic              accept;
	logic              out_free;
	logic              full;
	logic              found;
	logic              srch_start;
	logic              srch_finish;

	// result of an insert, delete or clear request, or of a finished search
	logic              load;
	logic [STAT_W-1:0] load_status;
	logic [PAY_W-1:0]  load_pay;
	logic [CNT_W-1:0]  count_nxt;

	cmd_t              cmd;

	logic [KEY_W-1:0]  cell_key     [DEPTH];
	logic [PAY_W-1:0]  cell_payload [DEPTH];
	logic [DEPTH-1:0]  gt_vec;
	logic [DEPTH-1:0]  match_vec;

	logic [IDX_W-1:0]  probe_idx;
	logic              srch_done;
	logic              srch_hit;
	logic [PAY_W-1:0]  srch_pay;

	assign in_mode    = s_tuser[1:0];
	assign in_key     = s_tdata[31:0];
	assign in_payload = s_tdata[63:32];

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = !(count_q < CNT_W'(DEPTH));
	assign found    = |match_vec;

	// row of cells: each takes from its left on insert, from its right on delete
	assign cmd.ins     = accept && (in_mode == MODE_INSERT) && !full;
	assign cmd.del     = accept && (in_mode == MODE_DELETE) && found;
	assign cmd.key     = in_key;
	assign cmd.payload = in_payload;
	assign cmd.count   = count_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             left_gt;
		logic [KEY_W-1:0] left_key;
		logic [PAY_W-1:0] left_payload;
		logic [KEY_W-1:0] right_key;
		logic [PAY_W-1:0] right_payload;

		if (i == 0) begin : g_head
			assign left_gt      = 1'b0;
			assign left_key     = '0;
			assign left_payload = '0;
		end else begin : g_body
			assign left_gt      = gt_vec[i-1];
			assign left_key     = cell_key[i-1];
			assign left_payload = cell_payload[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_key     = '0;
			assign right_payload = '0;
		end else begin : g_next
			assign right_key     = cell_key[i+1];
			assign right_payload = cell_payload[i+1];
		end

		sale_cell u_cell (
			.clk           (clk),
			.cmd           (cmd),
			.idx           (IDX_W'(i)),
			.left_gt       (left_gt),
			.left_key      (left_key),
			.left_payload  (left_payload),
			.right_key     (right_key),
			.right_payload (right_payload),
			.gt            (gt_vec[i]),
			.match         (match_vec[i]),
			.key           (cell_key[i]),
			.payload       (cell_payload[i])
		);
	end

	sale_search u_search (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (srch_start),
		.count         (count_q),
		.key           (in_key),
		.probe_key     (cell_key[probe_idx]),
		.probe_payload (cell_payload[probe_idx]),
		.probe_idx     (probe_idx),
		.done          (srch_done),
		.hit           (srch_hit),
		.hit_payload   (srch_pay)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_mode == MODE_LOOKUP)) begin
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (srch_done && out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// controller outputs
	always_comb begin
		s_tready    = 1'b0;
		srch_start  = 1'b0;
		srch_finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = out_free;
				srch_start = accept && (in_mode == MODE_LOOKUP);
			end
			ST_SEARCH: begin
				srch_finish = srch_done && out_free;
			end
			default: ;
		endcase
	end

	// result of the request in hand and the count it leaves
	always_comb begin
		load        = 1'b0;
		load_status = STAT_OK;
		load_pay    = '0;
		count_nxt   = count_q;
		if (srch_finish) begin
			load        = 1'b1;
			load_status = srch_hit ? STAT_OK : STAT_MISSING;
			load_pay    = srch_pay;
		end else if (accept) begin
			unique case (in_mode)
				MODE_INSERT: begin
					load = 1'b1;
					if (full) begin
						load_status = STAT_FULL;
					end else begin
						count_nxt = count_q + CNT_W'(1);
					end
				end
				MODE_DELETE: begin
					load = 1'b1;
					if (found) begin
						count_nxt = count_q - CNT_W'(1);
					end else begin
						load_status = STAT_MISSING;
					end
				end
				MODE_CLEAR: begin
					load      = 1'b1;
					count_nxt = '0;
				end
				MODE_LOOKUP: ; // answered when the search finishes
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			count_q <= count_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_status_q <= load_status;
			out_pay_q    <= load_pay;
			out_count_q  <= count_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, COUNT_W'(out_count_q), out_pay_q};

endmodule

[rtl/sale_cell.sv]
module sale_cell (
	input  logic                        clk,
	input  sale_pkg::cmd_t              cmd,
	input  logic [sale_pkg::IDX_W-1:0]  idx,
	input  logic                        left_gt,
	input  logic [sale_pkg::KEY_W-1:0]  left_key,
	input  logic [sale_pkg::PAY_W-1:0]  left_payload,
	input  logic [sale_pkg::KEY_W-1:0]  right_key,
	input  logic [sale_pkg::PAY_W-1:0]  right_payload,
	output logic                        gt,
	output logic                        match,
	output logic [sale_pkg::KEY_W-1:0]  key,
	output logic [sale_pkg::PAY_W-1:0]  payload
);
	import sale_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] payload_q;
	logic             occupied;
	logic             ge;

	assign occupied = CNT_W'(idx) < cmd.count;
	// an empty slot counts as greater, so a new entry lands at the tail
	assign gt       = !occupied || (cmd.key < key_q);
	assign match    = occupied && (key_q == cmd.key);
	assign ge       = !(key_q < cmd.key);
	assign key      = key_q;
	assign payload  = payload_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && gt) begin
			if (left_gt) begin
				key_q     <= left_key;
				payload_q <= left_payload;
			end else begin
				key_q     <= cmd.key;
				payload_q <= cmd.payload;
			end
		end else if (cmd.del && ge) begin
			// every slot from the first match upward pulls from its right neighbor
			key_q     <= right_key;
			payload_q <= right_payload;
		end
	end

endmodule

[rtl/sale_search.sv]
module sale_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sale_pkg::CNT_W-1:0]  count,
	input  logic [sale_pkg::KEY_W-1:0]  key,
	input  logic [sale_pkg::KEY_W-1:0]  probe_key,
	input  logic [sale_pkg::PAY_W-1:0]  probe_payload,
	output logic [sale_pkg::IDX_W-1:0]  probe_idx,
	output logic                        done,
	output logic                        hit,
	output logic [sale_pkg::PAY_W-1:0]  hit_payload
);
	import sale_pkg::*;

	logic [CNT_W-1:0] first_q;
	logic [CNT_W-1:0] hi_q;
	logic [KEY_W-1:0] key_q;
	logic [PAY_W-1:0] pay_q;
	logic             active_q;
	logic             done_q;
	logic             hit_q;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] mid;

	// hi_q is one past the last index still in range
	assign sum       = {1'b0, first_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
	assign mid       = sum[CNT_W:1];
	assign probe_idx = mid[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else if (start) begin
			active_q <= 1'b1;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
		end else if (active_q) begin
			if (!(first_q < hi_q)) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
			end else if (!(key_q < probe_key) && !(probe_key < key_q)) begin
				active_q <= 1'b0;
				done_q   <= 1'b1;
				hit_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			first_q <= '0;
			hi_q    <= count;
			key_q   <= key;
			pay_q   <= '0;
		end else if (active_q && (first_q < hi_q)) begin
			if (key_q < probe_key) begin
				hi_q <= mid;
			end else if (probe_key < key_q) begin
				first_q <= mid + CNT_W'(1);
			end else begin
				pay_q <= probe_payload;
			end
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign hit_payload = hit_q ? pay_q : '0;

endmodule
